// ----- sv/ssdp_pkg.sv -----
// ============================================================================
// ssdp_pkg
// Shared types, constants and helpers for the SSDP header value extractor.
// ============================================================================
package ssdp_pkg;

    // Default value length limits.
    localparam int NAME_CHARS_DEF = 31;
    localparam int TYPE_CHARS_DEF = 31;

    // A reply shorter than this many bytes is flagged invalid.
    localparam int MIN_BYTES  = 10;
    localparam int SEEN_W     = $clog2(MIN_BYTES + 1);

    // Header patterns, lower case, first character in the top byte.
    localparam int SERVER_LEN = 7;
    localparam int TYPE_LEN   = 3;
    localparam logic [SERVER_LEN*8-1:0] SERVER_HDR = "server:";
    localparam logic [TYPE_LEN*8-1:0]   TYPE_HDR   = "st:";

    // Fallback device name sent when only the ST header was found.
    localparam int UNKNOWN_LEN = 7;
    localparam int UNK_W       = $clog2(UNKNOWN_LEN);

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    // Result item kinds.
    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_TYPE    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } ssdp_in_t;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] char_out;
        logic       reply_valid;
        logic       found_server;
        logic       found_type;
        logic       run_last;
    } ssdp_out_t;

    // Results caused by one input byte, handed from the trackers to the emitter.
    typedef struct packed {
        logic       srv_emit;
        logic       typ_emit;
        logic [7:0] ch;
        logic       eop;
        logic       unknown;
        logic       reply_valid;
        logic       found_server;
        logic       found_type;
    } ssdp_bundle_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [7:0] unknown_char(input logic [UNK_W-1:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = "U";
            3'd1:    r = "n";
            3'd2:    r = "k";
            3'd3:    r = "n";
            3'd4:    r = "o";
            3'd5:    r = "w";
            3'd6:    r = "n";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/ssdp_trk.sv -----
// ============================================================================
// ssdp_trk
// Per-header tracker: matches the header at a line start, skips blanks and
// flags the value bytes to be emitted, up to a line break or the length limit.
// ============================================================================
module ssdp_trk #(
    parameter int                    HDR_LEN = ssdp_pkg::TYPE_LEN,
    parameter logic [HDR_LEN*8-1:0]  HDR     = ssdp_pkg::TYPE_HDR,
    parameter int                    LIMIT   = ssdp_pkg::TYPE_CHARS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       clear,
    input  logic [7:0] data_byte,
    input  logic       line_start,
    output logic       emit,
    output logic       found
);

    localparam int IDX_W = (HDR_LEN > 1) ? $clog2(HDR_LEN) : 1;
    localparam int LEN_W = $clog2(LIMIT + 1);

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_SKIP,
        PH_COPY,
        PH_DONE
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [7:0]         hdr_ch;
    logic               brk;
    logic               blank;
    logic               copy;

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        emit       = 1'b0;
        copy       = 1'b0;
        hdr_ch     = HDR[8*(HDR_LEN-1-int'(idx_reg)) +: 8];
        brk        = (data_byte == ssdp_pkg::CHAR_CR) || (data_byte == ssdp_pkg::CHAR_LF);
        blank      = (data_byte == ssdp_pkg::CHAR_SPACE) || (data_byte == ssdp_pkg::CHAR_TAB);

        case (phase_reg)
            PH_SEARCH: begin
                // A partial match keeps going past the line start.
                if (line_start || idx_reg != '0) begin
                    if (ssdp_pkg::to_lower(data_byte) == hdr_ch) begin
                        if (idx_reg == IDX_W'(HDR_LEN - 1)) begin
                            idx_next   = '0;
                            phase_next = PH_SKIP;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end else begin
                        idx_next = '0;
                    end
                end
            end
            PH_SKIP: begin
                if (blank) begin
                    phase_next = PH_SKIP;
                end else if (brk) begin
                    phase_next = PH_DONE;
                end else begin
                    copy = 1'b1;
                end
            end
            PH_COPY: begin
                copy = 1'b1;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        if (copy) begin
            if (brk || len_reg >= LEN_W'(LIMIT)) begin
                phase_next = PH_DONE;
            end else begin
                len_next   = len_reg + 1'b1;
                emit       = 1'b1;
                phase_next = (len_reg == LEN_W'(LIMIT - 1)) ? PH_DONE : PH_COPY;
            end
        end

        found = (len_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && clear)) begin
            phase_reg <= PH_SEARCH;
            idx_reg   <= '0;
            len_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ----- sv/ssdp_emit.sv -----
// ============================================================================
// ssdp_emit
// Result sequencer: holds the results caused by one input byte and sends
// them out one per cycle while m_ready is high, through the result register.
// ============================================================================
module ssdp_emit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  ssdp_pkg::ssdp_bundle_t bundle,
    output logic                   ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ssdp_pkg::ssdp_out_t    m_data
);

    logic                        srv_pend_reg, srv_pend_next;
    logic                        typ_pend_reg, typ_pend_next;
    logic                        unk_pend_reg, unk_pend_next;
    logic                        sum_pend_reg, sum_pend_next;
    logic [ssdp_pkg::UNK_W-1:0]  unk_idx_reg, unk_idx_next;
    ssdp_pkg::ssdp_bundle_t      hold_reg;
    logic                        m_valid_reg, m_valid_next;
    ssdp_pkg::ssdp_out_t         m_data_reg, m_data_next;
    logic                        out_free;
    logic                        more;

    always_comb begin
        srv_pend_next = srv_pend_reg;
        typ_pend_next = typ_pend_reg;
        unk_pend_next = unk_pend_reg;
        sum_pend_next = sum_pend_reg;
        unk_idx_next  = unk_idx_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        out_free      = !m_valid_reg || m_ready;

        if (out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            if (srv_pend_reg) begin
                srv_pend_next         = 1'b0;
                m_data_next.item_kind = ssdp_pkg::KIND_NAME;
                m_data_next.char_out  = hold_reg.ch;
            end else if (typ_pend_reg) begin
                typ_pend_next         = 1'b0;
                m_data_next.item_kind = ssdp_pkg::KIND_TYPE;
                m_data_next.char_out  = hold_reg.ch;
            end else if (unk_pend_reg) begin
                m_data_next.item_kind = ssdp_pkg::KIND_NAME;
                m_data_next.char_out  = ssdp_pkg::unknown_char(unk_idx_reg);
                if (unk_idx_reg == ssdp_pkg::UNK_W'(ssdp_pkg::UNKNOWN_LEN - 1)) begin
                    unk_pend_next = 1'b0;
                    unk_idx_next  = '0;
                end else begin
                    unk_idx_next = unk_idx_reg + 1'b1;
                end
            end else if (sum_pend_reg) begin
                sum_pend_next            = 1'b0;
                m_data_next.item_kind    = ssdp_pkg::KIND_SUMMARY;
                m_data_next.reply_valid  = hold_reg.reply_valid;
                m_data_next.found_server = hold_reg.found_server;
                m_data_next.found_type   = hold_reg.found_type;
            end else begin
                m_valid_next = 1'b0;
            end
        end

        // Whatever is left after this cycle's transaction still belongs to
        // the current byte; the one sent now is its last when nothing is left.
        more                 = srv_pend_next || typ_pend_next || unk_pend_next || sum_pend_next;
        m_data_next.run_last = out_free ? !more : m_data_reg.run_last;
        ready                = !more;

        if (load) begin
            srv_pend_next = bundle.srv_emit;
            typ_pend_next = bundle.typ_emit;
            unk_pend_next = bundle.unknown;
            sum_pend_next = bundle.eop;
            unk_idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srv_pend_reg <= 1'b0;
            typ_pend_reg <= 1'b0;
            unk_pend_reg <= 1'b0;
            sum_pend_reg <= 1'b0;
            unk_idx_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            srv_pend_reg <= srv_pend_next;
            typ_pend_reg <= typ_pend_next;
            unk_pend_reg <= unk_pend_next;
            sum_pend_reg <= sum_pend_next;
            unk_idx_reg  <= unk_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (load) begin
            hold_reg <= bundle;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- sv/ssdp_header_value_extractor.sv -----
// ============================================================================
// ssdp_header_value_extractor
// Extracts the SERVER and ST header values from an SSDP reply, byte by byte.
// ============================================================================
// A reply byte is taken in every cycle while m_ready is high if it causes at
// most one result; that result goes through the pending flags, then the
// result register. A byte that causes n results (both header values at once,
// or the packet end with the "Unknown" name and the summary, up to 9 in all)
// holds the result port, one result per cycle while m_ready is high, and
// s_ready stays low until its last result is being sent, so the single result
// register sets the rate. Header matching and value tracking are updated in
// the cycle the byte is accepted; run_last marks the final result of each
// byte; trackers, line start and byte count reset after end_of_packet.
module ssdp_header_value_extractor #(
    parameter int NAME_CHARS = ssdp_pkg::NAME_CHARS_DEF,
    parameter int TYPE_CHARS = ssdp_pkg::TYPE_CHARS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ssdp_pkg::ssdp_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ssdp_pkg::ssdp_out_t  m_data
);

    logic                        accept;
    logic                        line_start_reg, line_start_next;
    logic [ssdp_pkg::SEEN_W-1:0] seen_reg, seen_next;
    logic                        srv_emit, srv_found;
    logic                        typ_emit, typ_found;
    ssdp_pkg::ssdp_bundle_t      bundle;

    assign accept = s_valid && s_ready;

    ssdp_trk #(
        .HDR_LEN (ssdp_pkg::SERVER_LEN),
        .HDR     (ssdp_pkg::SERVER_HDR),
        .LIMIT   (NAME_CHARS)
    ) u_srv_trk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (accept),
        .clear      (s_data.end_of_packet),
        .data_byte  (s_data.data_byte),
        .line_start (line_start_reg),
        .emit       (srv_emit),
        .found      (srv_found)
    );

    ssdp_trk #(
        .HDR_LEN (ssdp_pkg::TYPE_LEN),
        .HDR     (ssdp_pkg::TYPE_HDR),
        .LIMIT   (TYPE_CHARS)
    ) u_typ_trk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (accept),
        .clear      (s_data.end_of_packet),
        .data_byte  (s_data.data_byte),
        .line_start (line_start_reg),
        .emit       (typ_emit),
        .found      (typ_found)
    );

    always_comb begin
        seen_next = seen_reg;
        if (seen_reg < ssdp_pkg::SEEN_W'(ssdp_pkg::MIN_BYTES)) begin
            seen_next = seen_reg + 1'b1;
        end
        line_start_next = (s_data.data_byte == ssdp_pkg::CHAR_LF);

        bundle.srv_emit     = srv_emit;
        bundle.typ_emit     = typ_emit;
        bundle.ch           = s_data.data_byte;
        bundle.eop          = s_data.end_of_packet;
        bundle.unknown      = s_data.end_of_packet && typ_found && !srv_found;
        bundle.reply_valid  = (seen_next == ssdp_pkg::SEEN_W'(ssdp_pkg::MIN_BYTES))
                              && (srv_found || typ_found);
        bundle.found_server = srv_found;
        bundle.found_type   = typ_found;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_data.end_of_packet)) begin
            line_start_reg <= 1'b1;
            seen_reg       <= '0;
        end else if (accept) begin
            line_start_reg <= line_start_next;
            seen_reg       <= seen_next;
        end
    end

    ssdp_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .bundle  (bundle),
        .ready   (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
